// ===== hdl/lss_pkg.sv =====
// Shared constants and types for the link session sequencer.
package lss_pkg;

  // Default width of the time value and of the stored heartbeat time
  localparam int TIME_WIDTH_DEF = 32;

  // Configuration register widths and reset values
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int INTERVAL_W  = 16;
  localparam int LIMIT_W     = 4;
  localparam int COUNT_W     = 4;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RST     = 16'd15;
  localparam logic [LIMIT_W-1:0]    PLUGIN_MAX_RST   = 4'd5;
  localparam logic [LIMIT_W-1:0]    ONLINE_LIMIT_RST = 4'd10;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HB_INTERVAL   = 2'd0,
    REG_PLUGIN_MAX    = 2'd1,
    REG_ONLINE_LIMIT  = 2'd2,
    REG_UNUSED        = 2'd3
  } cfg_reg_t;

  // Downlink codes
  typedef enum logic [1:0] {
    DL_NONE    = 2'd0,
    DL_PLUGIN  = 2'd1,
    DL_BOOT    = 2'd2,
    DL_OTHER   = 2'd3
  } downlink_t;

  // Session phases
  typedef enum logic [3:0] {
    PH_REGISTER      = 4'd0,
    PH_ONLINE        = 4'd1,
    PH_AUTH          = 4'd2,
    PH_HEARTBEAT     = 4'd3,
    PH_PLUGIN        = 4'd4,
    PH_PLUGIN_RESET  = 4'd5,
    PH_PLUGIN_ONLINE = 4'd6,
    PH_PLUGIN_AUTH   = 4'd7,
    PH_PLUGIN_HB     = 4'd8,
    PH_DISCONNECT    = 4'd9
  } phase_t;

  // Actions consulted in each phase
  typedef enum logic [3:0] {
    ACT_REGISTER      = 4'd0,
    ACT_ONLINE        = 4'd1,
    ACT_AUTH          = 4'd2,
    ACT_UDP_DOWNLINK  = 4'd3,
    ACT_HEARTBEAT     = 4'd4,
    ACT_PLUGIN        = 4'd5,
    ACT_DISCONNECT    = 4'd6,
    ACT_PLUGIN_ONLINE = 4'd7,
    ACT_PLUGIN_AUTH   = 4'd8,
    ACT_TCP_DOWNLINK  = 4'd9,
    ACT_PLUGIN_HB     = 4'd10
  } action_t;

  // One result as held in the output register and the skid stage
  typedef struct packed {
    logic [3:0]         phase;
    logic [3:0]         action_taken;
    logic [COUNT_W-1:0] plugin_retries;
    logic [COUNT_W-1:0] online_retries;
    logic               heartbeat_refreshed;
  } result_t;

endpackage

// ===== hdl/link_session_sequencer_top.sv =====
// Link session sequencer: one phase step per request, registered result with skid.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one step: now_seconds, action_ok and
//   downlink_code. A step is taken at a clock edge with in_valid high and in_stall low.
//   The step is evaluated against the current phase and its result
//   (phase, action_taken, both retry counters, heartbeat_refreshed) appears on the
//   output channel (out_valid / out_stall) on the next cycle if the output is free.
//   Throughput is one step per cycle while in_stall is low; the rate is set by the
//   phase/counter/timer update loop (one 33-bit add and compare).
//   When the receiver stalls, the output register holds its result and one more
//   step is still taken into a skid register; in_stall rises only when both are
//   full, and drops as soon as the output drains.
//   Configuration (cfg_we, cfg_index, cfg_data) writes a register at the clock edge
//   with cfg_we high; writes to an unused index are ignored. Write only while idle.
//   Synchronous reset (rst) returns to the register phase, clears the counters and
//   the last heartbeat time, loads the default interval and limits, and empties
//   the output and skid registers.
module link_session_sequencer_top #(
  parameter int TIME_WIDTH = lss_pkg::TIME_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [lss_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lss_pkg::CFG_DATA_W-1:0]  cfg_data,
  // step input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [TIME_WIDTH-1:0]          now_seconds,
  input  logic                           action_ok,
  input  logic [1:0]                     downlink_code,
  // result output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [3:0]                     phase,
  output logic [3:0]                     action_taken,
  output logic [lss_pkg::COUNT_W-1:0]    plugin_retries,
  output logic [lss_pkg::COUNT_W-1:0]    online_retries,
  output logic                           heartbeat_refreshed
);
  import lss_pkg::*;

  // configuration registers
  logic [INTERVAL_W-1:0] heartbeat_interval;
  logic [LIMIT_W-1:0]    plugin_retry_max;
  logic [LIMIT_W-1:0]    plugin_online_retry_limit;

  // sequencer state
  phase_t                current_phase, current_phase_next;
  logic [TIME_WIDTH-1:0] last_hb_time, last_hb_time_next;
  logic [COUNT_W-1:0]    plugin_retry_count, plugin_retry_count_next;
  logic [COUNT_W-1:0]    online_fail_count, online_fail_count_next;

  // output register and skid stage
  result_t out_res, skid_res, step_res;
  logic    skid_full;

  logic in_accept, out_take;
  logic interval_open;
  logic [TIME_WIDTH:0]   hb_deadline;
  logic [COUNT_W:0]      retry_inc;
  logic [COUNT_W:0]      online_inc;
  action_t               act;
  logic                  refreshed;
  downlink_t             dl;

  assign in_stall  = skid_full;
  assign in_accept = in_valid && !skid_full;
  assign out_take  = out_valid && !out_stall;
  assign dl        = downlink_t'(downlink_code);

  // Heartbeat timer: deadline formed one bit wider so it never wraps
  assign hb_deadline   = {1'b0, last_hb_time}
                       + {{(TIME_WIDTH + 1 - INTERVAL_W){1'b0}}, heartbeat_interval};
  assign interval_open = {1'b0, now_seconds} < hb_deadline;

  // counters incremented one bit wider before the limit compare
  assign retry_inc  = {1'b0, plugin_retry_count} + {{COUNT_W{1'b0}}, 1'b1};
  assign online_inc = {1'b0, online_fail_count} + {{COUNT_W{1'b0}}, 1'b1};

  // Phase step
  always_comb begin
    current_phase_next      = current_phase;
    last_hb_time_next       = last_hb_time;
    plugin_retry_count_next = plugin_retry_count;
    online_fail_count_next  = online_fail_count;
    act                     = ACT_REGISTER;
    refreshed               = 1'b0;
    unique case (current_phase)
      PH_REGISTER: begin
        act = ACT_REGISTER;
        if (action_ok) current_phase_next = PH_ONLINE;
      end
      PH_ONLINE: begin
        act = ACT_ONLINE;
        current_phase_next = action_ok ? PH_AUTH : PH_REGISTER;
      end
      PH_AUTH: begin
        act = ACT_AUTH;
        current_phase_next = action_ok ? PH_HEARTBEAT : PH_ONLINE;
      end
      PH_HEARTBEAT: begin
        if (interval_open) begin
          act = ACT_UDP_DOWNLINK;
          if (dl == DL_PLUGIN) current_phase_next = PH_PLUGIN;
          else if (dl == DL_BOOT) current_phase_next = PH_ONLINE;
        end else begin
          act = ACT_HEARTBEAT;
          if (action_ok) begin
            last_hb_time_next = now_seconds;
            refreshed         = 1'b1;
          end else begin
            current_phase_next = PH_ONLINE;
          end
        end
      end
      PH_PLUGIN: begin
        act = ACT_PLUGIN;
        if (action_ok) begin
          current_phase_next      = PH_PLUGIN_ONLINE;
          plugin_retry_count_next = '0;
        end else if (retry_inc > {1'b0, plugin_retry_max}) begin
          current_phase_next      = PH_ONLINE;
          plugin_retry_count_next = '0;
        end else begin
          plugin_retry_count_next = retry_inc[COUNT_W-1:0];
        end
      end
      PH_PLUGIN_RESET: begin
        act = ACT_DISCONNECT;
        current_phase_next = PH_PLUGIN;
      end
      PH_PLUGIN_ONLINE: begin
        act = ACT_PLUGIN_ONLINE;
        if (action_ok) begin
          current_phase_next     = PH_PLUGIN_AUTH;
          online_fail_count_next = '0;
        end else if (online_inc <= {1'b0, plugin_online_retry_limit}) begin
          current_phase_next     = PH_PLUGIN_RESET;
          online_fail_count_next = online_inc[COUNT_W-1:0];
        end else begin
          current_phase_next     = PH_DISCONNECT;
          online_fail_count_next = '0;
        end
      end
      PH_PLUGIN_AUTH: begin
        act = ACT_PLUGIN_AUTH;
        current_phase_next = action_ok ? PH_PLUGIN_HB : PH_PLUGIN_RESET;
      end
      PH_PLUGIN_HB: begin
        if (interval_open) begin
          act = ACT_TCP_DOWNLINK;
          if (dl != DL_NONE) current_phase_next = PH_DISCONNECT;
        end else begin
          act = ACT_PLUGIN_HB;
          if (action_ok) begin
            last_hb_time_next = now_seconds;
            refreshed         = 1'b1;
          end else begin
            current_phase_next = PH_PLUGIN_RESET;
          end
        end
      end
      PH_DISCONNECT: begin
        act = ACT_DISCONNECT;
        current_phase_next = PH_ONLINE;
      end
      default: begin
        // unused phase codes hold the phase
        act = ACT_REGISTER;
      end
    endcase
  end

  always_comb begin
    step_res.phase               = current_phase_next;
    step_res.action_taken        = act;
    step_res.plugin_retries      = plugin_retry_count_next;
    step_res.online_retries      = online_fail_count_next;
    step_res.heartbeat_refreshed = refreshed;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      heartbeat_interval        <= INTERVAL_RST;
      plugin_retry_max          <= PLUGIN_MAX_RST;
      plugin_online_retry_limit <= ONLINE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HB_INTERVAL:  heartbeat_interval        <= cfg_data[INTERVAL_W-1:0];
        REG_PLUGIN_MAX:   plugin_retry_max          <= cfg_data[LIMIT_W-1:0];
        REG_ONLINE_LIMIT: plugin_online_retry_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state, advanced once per accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      current_phase      <= PH_REGISTER;
      last_hb_time       <= '0;
      plugin_retry_count <= '0;
      online_fail_count  <= '0;
    end else if (in_accept) begin
      current_phase      <= current_phase_next;
      last_hb_time       <= last_hb_time_next;
      plugin_retry_count <= plugin_retry_count_next;
      online_fail_count  <= online_fail_count_next;
    end
  end

  // Output register with one-entry skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else begin
      if (out_valid && !out_take) begin
        // output held: a new request lands in the skid stage
        if (in_accept) skid_full <= 1'b1;
      end else if (skid_full) begin
        out_valid <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        out_valid <= in_accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_take) begin
      if (in_accept) skid_res <= step_res;
    end else if (skid_full) begin
      out_res <= skid_res;
    end else if (in_accept) begin
      out_res <= step_res;
    end
  end

  assign phase               = out_res.phase;
  assign action_taken        = out_res.action_taken;
  assign plugin_retries      = out_res.plugin_retries;
  assign online_retries      = out_res.online_retries;
  assign heartbeat_refreshed = out_res.heartbeat_refreshed;

  // Checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_valid)
    else $error("skid stage full while output register empty");

  a_refresh_action: assert property (@(posedge clk) disable iff (rst)
    (out_valid && heartbeat_refreshed) |->
      (action_taken == ACT_HEARTBEAT || action_taken == ACT_PLUGIN_HB))
    else $error("heartbeat refresh without a heartbeat action");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    current_phase <= PH_DISCONNECT)
    else $error("phase register holds an unused code");

  a_hb_time_hold: assert property (@(posedge clk) disable iff (rst)
    !in_accept |=> $stable(last_hb_time))
    else $error("heartbeat time changed without a request");

endmodule

// ===== sim/lss_session_checker.sv =====
// Checker for the link session sequencer: predicts every step result and compares it.
`timescale 1ns / 1ps
module lss_session_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [lss_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [lss_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [lss_pkg::TIME_WIDTH_DEF-1:0] now_seconds,
  input  logic                               action_ok,
  input  logic [1:0]                         downlink_code,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [3:0]                         phase,
  input  logic [3:0]                         action_taken,
  input  logic [lss_pkg::COUNT_W-1:0]        plugin_retries,
  input  logic [lss_pkg::COUNT_W-1:0]        online_retries,
  input  logic                               heartbeat_refreshed,
  output int                                 n_pending,
  output int                                 n_failures,
  output lss_pkg::phase_t                    session_phase
);
  import lss_pkg::*;

  localparam int TW = TIME_WIDTH_DEF;

  // predicted session state and register copies
  phase_t                sess_phase;
  logic [TW-1:0]         last_hb;
  logic [COUNT_W-1:0]    plug_fail;
  logic [COUNT_W-1:0]    onl_fail;
  logic [INTERVAL_W-1:0] hb_interval;
  logic [LIMIT_W-1:0]    plug_max;
  logic [LIMIT_W-1:0]    onl_limit;

  result_t awaited_results[$];
  result_t exp_r;
  int      failures;

  // interval still running: compare one bit wider so the deadline never wraps
  function automatic logic hb_window_open(input logic [TW-1:0] now);
    logic [TW:0] deadline;
    deadline = {1'b0, last_hb};
    deadline = deadline + hb_interval;
    return {1'b0, now} < deadline;
  endfunction

  // one session step: new phase, action consulted, counters
  task automatic step_session(input logic [TW-1:0] now, input logic ok, input downlink_t dl,
                              output result_t res);
    phase_t     nxt;
    action_t    act;
    logic       refreshed;
    logic [4:0] tally;
    nxt       = sess_phase;
    act       = ACT_REGISTER;
    refreshed = 1'b0;
    case (sess_phase)
      PH_REGISTER: begin
        if (ok) nxt = PH_ONLINE;
      end
      PH_ONLINE: begin
        act = ACT_ONLINE;
        nxt = ok ? PH_AUTH : PH_REGISTER;
      end
      PH_AUTH: begin
        act = ACT_AUTH;
        nxt = ok ? PH_HEARTBEAT : PH_ONLINE;
      end
      PH_HEARTBEAT: begin
        if (hb_window_open(now)) begin
          // poll the downlink while the interval runs
          act = ACT_UDP_DOWNLINK;
          if (dl == DL_PLUGIN) nxt = PH_PLUGIN;
          else if (dl == DL_BOOT) nxt = PH_ONLINE;
        end else begin
          act = ACT_HEARTBEAT;
          if (ok) begin
            last_hb   = now;
            refreshed = 1'b1;
          end else begin
            nxt = PH_ONLINE;
          end
        end
      end
      PH_PLUGIN: begin
        act = ACT_PLUGIN;
        if (ok) begin
          nxt       = PH_PLUGIN_ONLINE;
          plug_fail = '0;
        end else begin
          // counter bumped one bit wider, so a limit of 15 still trips
          tally = {1'b0, plug_fail} + 5'd1;
          if (tally > {1'b0, plug_max}) begin
            tally = '0;
            nxt   = PH_ONLINE;
          end
          plug_fail = tally[3:0];
        end
      end
      PH_PLUGIN_RESET: begin
        act = ACT_DISCONNECT;
        nxt = PH_PLUGIN;
      end
      PH_PLUGIN_ONLINE: begin
        act = ACT_PLUGIN_ONLINE;
        if (ok) begin
          nxt      = PH_PLUGIN_AUTH;
          onl_fail = '0;
        end else begin
          tally = {1'b0, onl_fail} + 5'd1;
          if (tally <= {1'b0, onl_limit}) begin
            nxt = PH_PLUGIN_RESET;
          end else begin
            nxt   = PH_DISCONNECT;
            tally = '0;
          end
          onl_fail = tally[3:0];
        end
      end
      PH_PLUGIN_AUTH: begin
        act = ACT_PLUGIN_AUTH;
        nxt = ok ? PH_PLUGIN_HB : PH_PLUGIN_RESET;
      end
      PH_PLUGIN_HB: begin
        if (hb_window_open(now)) begin
          act = ACT_TCP_DOWNLINK;
          if (dl != DL_NONE) nxt = PH_DISCONNECT;
        end else begin
          act = ACT_PLUGIN_HB;
          if (ok) begin
            last_hb   = now;
            refreshed = 1'b1;
          end else begin
            nxt = PH_PLUGIN_RESET;
          end
        end
      end
      PH_DISCONNECT: begin
        act = ACT_DISCONNECT;
        nxt = PH_ONLINE;
      end
      default: ;
    endcase
    sess_phase              = nxt;
    res.phase               = nxt;
    res.action_taken        = act;
    res.plugin_retries      = plug_fail;
    res.online_retries      = onl_fail;
    res.heartbeat_refreshed = refreshed;
  endtask

  task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endtask

  // watch both channels and the register port
  always @(posedge clk) begin
    if (rst) begin
      hb_interval = INTERVAL_RST;
      plug_max    = PLUGIN_MAX_RST;
      onl_limit   = ONLINE_LIMIT_RST;
      sess_phase  = PH_REGISTER;
      last_hb     = '0;
      plug_fail   = '0;
      onl_fail    = '0;
      failures    = 0;
      awaited_results.delete();
    end else begin
      // result leaving the block
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("result with no request waiting: phase %0d, action_taken %0d",
                 phase, action_taken);
          failures++;
        end else begin
          exp_r = awaited_results.pop_front();
          check_field("phase", exp_r.phase, phase);
          check_field("action_taken", exp_r.action_taken, action_taken);
          check_field("plugin_retries", exp_r.plugin_retries, plugin_retries);
          check_field("online_retries", exp_r.online_retries, online_retries);
          check_field("heartbeat_refreshed", {3'b000, exp_r.heartbeat_refreshed},
                      {3'b000, heartbeat_refreshed});
        end
      end
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_HB_INTERVAL:  hb_interval = cfg_data;
          REG_PLUGIN_MAX:   plug_max    = cfg_data[LIMIT_W-1:0];
          REG_ONLINE_LIMIT: onl_limit   = cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      // request taken by the block
      if (in_valid && !in_stall) begin
        step_session(now_seconds, action_ok, downlink_t'(downlink_code), exp_r);
        awaited_results.push_back(exp_r);
      end
    end
    n_pending     <= awaited_results.size();
    n_failures    <= failures;
    session_phase <= sess_phase;
  end

endmodule

// ===== sim/link_session_sequencer_top_tb.sv =====
// Testbench top: drives session steps and register writes, then gives the verdict.
`timescale 1ns / 1ps
module link_session_sequencer_top_tb;
  import lss_pkg::*;

  localparam int TW          = TIME_WIDTH_DEF;
  localparam int N_PHASES    = 6;
  localparam int PHASE_STEPS = 175;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 600000;

  typedef enum int {
    MIX_GUIDED,
    MIX_NORMAL,
    MIX_FAILING,
    MIX_NOISE,
    MIX_TIMER
  } step_mix_t;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   cfg_we        = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index     = REG_HB_INTERVAL;
  logic [CFG_DATA_W-1:0]  cfg_data      = '0;
  logic                   in_valid      = 1'b0;
  logic                   in_stall;
  logic [TW-1:0]          now_seconds   = '0;
  logic                   action_ok     = 1'b0;
  logic [1:0]             downlink_code = DL_NONE;
  logic                   out_valid;
  logic                   out_stall     = 1'b0;
  logic [3:0]             phase;
  logic [3:0]             action_taken;
  logic [COUNT_W-1:0]     plugin_retries;
  logic [COUNT_W-1:0]     online_retries;
  logic                   heartbeat_refreshed;

  int     n_pending;
  int     n_failures;
  phase_t session_phase;

  int            idle_pct     = 0;
  int            stall_pct    = 0;
  logic          hold_flip    = 1'b0;
  logic          hold_seen    = 1'b0;
  int            hold_left    = 0;
  int            cycle_count  = 0;
  logic [TW-1:0] now_s        = '0;
  int            cur_interval = int'(INTERVAL_RST);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  link_session_sequencer_top #(.TIME_WIDTH(TW)) u_top (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .now_seconds, .action_ok, .downlink_code,
    .out_valid, .out_stall, .phase, .action_taken, .plugin_retries, .online_retries,
    .heartbeat_refreshed
  );

  lss_session_checker u_checker (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .now_seconds, .action_ok, .downlink_code,
    .out_valid, .out_stall, .phase, .action_taken, .plugin_retries, .online_retries,
    .heartbeat_refreshed, .n_pending, .n_failures, .session_phase
  );

  // result side: random stall, or a long hold-off when the flip bit toggles
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_seen <= hold_flip;
    end else if (hold_seen != hold_flip) begin
      hold_seen <= hold_flip;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("link_session_sequencer_top_tb: FAIL");
      $finish;
    end
  end

  function automatic downlink_t pick_downlink();
    int r;
    r = $urandom_range(99);
    if (r < 55) return DL_NONE;
    if (r < 80) return DL_PLUGIN;
    if (r < 90) return DL_BOOT;
    return DL_OTHER;
  endfunction

  // offer one request and hold it until the block takes it
  task automatic send_step(input logic [TW-1:0] t, input logic ok, input downlink_t dl);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    now_seconds   <= t;
    action_ok     <= ok;
    downlink_code <= dl;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic configure(input logic [INTERVAL_W-1:0] interval,
                           input logic [LIMIT_W-1:0] pmax, input logic [LIMIT_W-1:0] olimit);
    write_reg(REG_HB_INTERVAL, interval);
    write_reg(REG_PLUGIN_MAX, pmax);
    write_reg(REG_ONLINE_LIMIT, olimit);
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_interval = int'(interval);
  endtask

  // stop offering and wait until every result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
    repeat (2) @(posedge clk);
  endtask

  // segments of differently shaped requests; time mostly moves forward, since the
  // last heartbeat time never goes down and a jump back would freeze the timer
  task automatic run_random(input int count, input bit wrap_time);
    step_mix_t     mix;
    int            seg_len;
    int            k;
    logic          ok;
    downlink_t     dl;
    logic [TW-1:0] t;
    while (count > 0) begin
      mix     = step_mix_t'($urandom_range(4));
      seg_len = (mix == MIX_GUIDED) ? $urandom_range(80, 40) : $urandom_range(40, 8);
      if (seg_len > count) seg_len = count;
      for (k = 0; k < seg_len; k++) begin
        dl = pick_downlink();
        ok = ($urandom_range(99) < 85);
        case (mix)
          MIX_GUIDED: begin
            // an idle gap so the phase after the previous request is known;
            // steer into plugin bring-up and pile up plugin-online failures
            in_valid <= 1'b0;
            @(posedge clk);
            now_s += $urandom_range(2);
            case (session_phase)
              PH_HEARTBEAT:     dl = DL_PLUGIN;
              PH_PLUGIN:        ok = ($urandom_range(99) < 75);
              PH_PLUGIN_ONLINE: ok = ($urandom_range(99) < 5);
              PH_PLUGIN_HB:     dl = ($urandom_range(99) < 80) ? DL_NONE : dl;
              default: ;
            endcase
            t = now_s;
          end
          MIX_NORMAL: begin
            now_s += $urandom_range(3);
            t = now_s;
          end
          MIX_FAILING: begin
            ok = ($urandom_range(99) < 30);
            now_s += $urandom_range(3);
            t = now_s;
          end
          MIX_NOISE: begin
            ok = 1'($urandom_range(1));
            dl = downlink_t'($urandom_range(3));
            t  = wrap_time ? TW'($urandom) : TW'($urandom_range(now_s));
          end
          default: begin
            // jumps around the heartbeat deadline
            now_s += $urandom_range(cur_interval + 2);
            t = now_s;
          end
        endcase
        send_step(t, ok, dl);
      end
      count -= seg_len;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed walk with reset settings: interval 15
    send_step(32'hFFFF_FFFF, 1'b0, DL_OTHER);  // register fails, time unused
    send_step(32'd0, 1'b1, DL_NONE);           // -> online
    send_step(32'd0, 1'b0, DL_NONE);           // online fails -> register
    send_step(32'd1, 1'b1, DL_NONE);
    send_step(32'd1, 1'b1, DL_NONE);           // -> auth
    send_step(32'd1, 1'b0, DL_NONE);           // auth fails -> online
    send_step(32'd1, 1'b1, DL_NONE);
    send_step(32'd2, 1'b1, DL_NONE);           // -> heartbeat
    send_step(32'd5, 1'b0, DL_NONE);           // poll, nothing
    send_step(32'd6, 1'b1, DL_OTHER);          // poll, other code keeps phase
    send_step(32'd7, 1'b1, DL_BOOT);           // return to boot -> online
    send_step(32'd8, 1'b1, DL_NONE);
    send_step(32'd9, 1'b1, DL_NONE);           // -> heartbeat
    send_step(32'd15, 1'b1, DL_NONE);          // deadline reached exactly: heartbeat sent
    send_step(32'd16, 1'b0, DL_PLUGIN);        // plugin request
    send_step(32'd16, 1'b0, DL_NONE);          // plugin fails once
    send_step(32'd17, 1'b1, DL_NONE);          // -> plugin online
    send_step(32'd17, 1'b0, DL_NONE);          // fails -> plugin reset
    send_step(32'd18, 1'b0, DL_OTHER);         // reset ignores outcome
    send_step(32'd18, 1'b1, DL_NONE);
    send_step(32'd19, 1'b1, DL_NONE);          // -> plugin auth
    send_step(32'd19, 1'b1, DL_NONE);          // -> plugin heartbeat
    send_step(32'd20, 1'b1, DL_NONE);          // tcp poll, stays
    send_step(32'd31, 1'b1, DL_NONE);          // expired: plugin heartbeat sent
    send_step(32'd32, 1'b1, DL_BOOT);          // tcp code -> disconnect
    send_step(32'd32, 1'b0, DL_NONE);          // disconnect -> online
    drain();
    now_s = 32'd40;

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        1: configure(16'd0, 4'd0, 4'd0);
        2: configure(16'hFFFF, 4'd14, 4'd14);
        3: configure(16'd3, 4'd15, 4'd15);
        4: begin
          write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
          configure(16'd1, 4'd1, 4'd1);
        end
        5: begin
          configure(INTERVAL_W'($urandom_range(40, 2)), LIMIT_W'($urandom_range(15)),
                    LIMIT_W'($urandom_range(15)));
          // run the clock up to the top so it wraps during this phase
          now_s = 32'hFFFF_FF00;
        end
        default: begin
          // long receiver hold-off while requests keep coming
          hold_flip <= ~hold_flip;
        end
      endcase
      case (p % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 67;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 67;
        end
        default: begin
          idle_pct  = 32;
          stall_pct = 32;
        end
      endcase
      run_random(PHASE_STEPS, p == N_PHASES - 1);
      drain();
    end

    repeat (4) @(posedge clk);
    if (n_failures == 0) begin
      $display("link_session_sequencer_top_tb: PASS");
    end else begin
      $display("link_session_sequencer_top_tb: FAIL");
    end
    $finish;
  end

endmodule
